### rtl/core/deq_pkg.sv
package deq_pkg;

   localparam int DataW = 32;

   // operation codes
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_REAR   = 3'd3;
   localparam logic [2:0] MODE_LIST_FWD   = 3'd4;
   localparam logic [2:0] MODE_LIST_REV   = 3'd5;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic       latch_req;
      logic       push_front;
      logic       push_rear;
      logic       pop_front;
      logic       pop_rear;
      logic       list_start;
      logic       list_next;
      logic       emit_status;
      logic       emit_data;
      logic       emit_last;
      logic [1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] mode;
      logic       full;
      logic       empty;
      logic       can_load;
      logic       list_end;
   } sts_type;

endpackage

### rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values in a ring of DEPTH entries.
// Request channel (req_*): one beat carries a mode and a value. Modes are push
//   front, push rear, pop front, pop rear, list front-to-rear, list rear-to-front;
//   codes six and seven are swallowed with no response.
// Response channel (rsp_*): push and pop give one beat (pop carries the removed
//   value); a listing gives one beat per stored value, rsp_last on the final one.
//   Full push and empty pop/list give a single beat with a nonzero status.
// Timing: one request is worked at a time. req_ready is high only while the
//   controller is idle. A push or a failed op loads its beat from S_EXEC; a pop
//   reads the ring in S_EXEC and loads the beat in S_POP; a listing reads in
//   S_EXEC and then streams one beat per cycle from S_LIST while rsp_ready
//   allows. The controller returns to S_IDLE as the last beat is loaded and
//   takes the next request there. The ring memory read is registered, which is
//   why pops and listings pass through S_POP or S_LIST.
// Stalls: rsp_ready low holds the output register; the controller waits and the
//   ring read data is held until the beat can be loaded.
// Reset: synchronous; the queue comes up empty and the response register idle.
//   Ring contents are not cleared (only written entries are ever read).
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_mode,
   input  logic signed [DataW-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [DataW-1:0] rsp_item_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   cmd_type cmd;   // controller commands
   sts_type sts;   // datapath flags

   // sequencing: accept, execute, pop read-back, list streaming
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // pointers, count, ring memory and the response register
   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

### rtl/core/deq_ram.sv
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/deq_ctrl.sv
module deq_ctrl import deq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_POP  = 4'b0100,
      S_LIST = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.can_load) begin
               state_in = S_IDLE;
               unique case (sts.mode)
                  MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                     cmd.emit_status = 1'b1;
                     if (sts.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.status     = ST_OK;
                        cmd.push_front = (sts.mode == MODE_PUSH_FRONT);
                        cmd.push_rear  = (sts.mode == MODE_PUSH_REAR);
                     end
                  end
                  MODE_POP_FRONT, MODE_POP_REAR: begin
                     if (sts.empty) begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = ST_EMPTY;
                     end else begin
                        cmd.pop_front = (sts.mode == MODE_POP_FRONT);
                        cmd.pop_rear  = (sts.mode == MODE_POP_REAR);
                        state_in      = S_POP;
                     end
                  end
                  MODE_LIST_FWD, MODE_LIST_REV: begin
                     if (sts.empty) begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = ST_EMPTY;
                     end else begin
                        cmd.list_start = 1'b1;
                        state_in       = S_LIST;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;   // unused codes: dropped silently
                  end
               endcase
            end
         end
         S_POP: begin
            if (sts.can_load) begin
               cmd.emit_data = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LIST: begin
            if (sts.can_load) begin
               cmd.emit_data = 1'b1;
               cmd.emit_last = sts.list_end;
               if (sts.list_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.list_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/deq_dp.sv
module deq_dp import deq_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [2:0]              req_mode,
   input  logic signed [DataW-1:0] req_value,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic signed [DataW-1:0] rsp_item_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DepthA  = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

   // ring index add, both operands below DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DepthA) begin
         s = s - DepthA;
      end
      return s[AW-1:0];
   endfunction

   logic [2:0]              mode_ff;
   logic signed [DataW-1:0] value_ff;
   logic [AW-1:0]           front_ff, front_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           k_ff, k_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] rsp_value_ff;
   logic [1:0]              rsp_status_ff;
   logic                    rsp_last_ff;

   logic [CW-1:0]    cnt_m1;
   logic [AW-1:0]    k_sel;
   logic [CW-1:0]    rev_off;
   logic [AW-1:0]    list_off;
   logic [AW-1:0]    front_dec, front_inc;
   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [DataW-1:0] ram_rdata;
   logic             emit;

   assign cnt_m1    = count_ff - 1'b1;
   assign k_sel     = cmd.list_start ? '0 : k_ff + 1'b1;
   assign rev_off   = cnt_m1 - CW'(k_sel);
   assign list_off  = (mode_ff == MODE_LIST_REV) ? rev_off[AW-1:0] : k_sel;
   assign front_dec = (front_ff == '0) ? LastIdx : front_ff - 1'b1;
   assign front_inc = (front_ff == LastIdx) ? '0 : front_ff + 1'b1;

   assign ram_we    = cmd.push_front | cmd.push_rear;
   assign ram_waddr = cmd.push_front ? front_dec : wrap_add(front_ff, count_ff[AW-1:0]);
   assign ram_re    = cmd.pop_front | cmd.pop_rear | cmd.list_start | cmd.list_next;

   always_comb begin
      if (cmd.pop_front) begin
         ram_raddr = front_ff;
      end else if (cmd.pop_rear) begin
         ram_raddr = wrap_add(front_ff, cnt_m1[AW-1:0]);
      end else begin
         ram_raddr = wrap_add(front_ff, list_off);
      end
   end

   deq_ram #(
      .WIDTH (DataW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (value_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.push_front) begin
         front_in = front_dec;
      end else if (cmd.pop_front) begin
         front_in = front_inc;
      end
      if (ram_we) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop_front | cmd.pop_rear) begin
         count_in = cnt_m1;
      end
   end

   assign k_in         = (cmd.list_start | cmd.list_next) ? k_sel : k_ff;
   assign emit         = cmd.emit_status | cmd.emit_data;
   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.latch_req) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
      if (cmd.emit_status) begin
         rsp_value_ff  <= '0;
         rsp_status_ff <= cmd.status;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit_data) begin
         rsp_value_ff  <= ram_rdata;
         rsp_status_ff <= ST_OK;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign sts.mode     = mode_ff;
   assign sts.full     = (count_ff == DepthC);
   assign sts.empty    = (count_ff == '0);
   assign sts.can_load = ~rsp_valid_ff | rsp_ready;
   assign sts.list_end = (CW'(k_ff) == cnt_m1);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### rtl/core/deq_checker.sv
module deq_checker import deq_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [DataW-1:0] rsp_item_value,
   input logic [1:0]              rsp_status,
   input logic                    rsp_last
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_value)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("response changed while stalled");

   // failed ops carry zero data and close the request
   a_fail_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_item_value == '0 && rsp_last)
      else $error("error beat with data or without last");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_EMPTY
         || rsp_status == ST_FULL)
      else $error("undefined response status");

   // no response and ready for a request right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
